// ===== hw/rtl/assert_macros.svh =====
// assertion helpers for the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/aft_pkg.sv =====
`timescale 1ns / 1ps

package aft_pkg;

    // line constants
    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'h8408;

    // register reset values
    localparam logic [7:0] UNIT0_ADDR_RST = 8'h24;
    localparam logic [7:0] UNIT1_ADDR_RST = 8'h25;

    // register indexes on the configuration port
    localparam logic CFG_UNIT0 = 1'b0;
    localparam logic CFG_UNIT1 = 1'b1;

    // default depth of the queue between front and back
    localparam int FIFO_DEPTH_DEF = 4;

    // reflected crc-16/x-25 update over one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // crc after the reset address bytes, used as reset values
    localparam logic [15:0] CRC_ADDR0_RST = crc_byte(CRC_INIT, UNIT0_ADDR_RST);
    localparam logic [15:0] CRC_ADDR1_RST = crc_byte(CRC_INIT, UNIT1_ADDR_RST);

    // one classified request handed from front to back
    typedef struct packed {
        logic        has_addr;
        logic [7:0]  addr;
        logic [7:0]  data;
        logic        last;
        logic [15:0] crc_fin;
    } job_t;

endpackage

// ===== hw/rtl/addressed_frame_transmitter_top.sv =====
`timescale 1ns / 1ps

// Framer for a 9-bit addressed serial link with CRC-16/X-25. Payload bytes enter one per
// request; at a frame start the selected unit's address goes out first with the address bit
// set, then every byte with it clear, and after the byte marked last come the CRC low byte,
// the CRC high byte and the flag 0x7E, which carries the address bit and tlast. The front
// stage takes one byte every cycle while its queue (FIFO_DEPTH entries) has room and runs the
// CRC a byte per cycle; the back stage emits one symbol per cycle while it has work and the
// output is ready, so a frame of N bytes becomes N + 4 output symbols and the symbol
// serializer sets the sustained rate. With the queue empty and the back stage idle the first
// symbol of a byte passes through the queue, the job register and the output register
// before it is offered on the output. Address writes take effect at the next frame start.

`include "assert_macros.svh"

module addressed_frame_transmitter_top
#(
    parameter int FIFO_DEPTH = aft_pkg::FIFO_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // data_byte
    input  logic       s_tuser,   // unit_select
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // symbol_byte
    output logic       m_tuser,   // address_bit
    output logic       m_tlast,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data
);

    localparam int CW = $clog2(FIFO_DEPTH + 1);

    aft_pkg::job_t front_job;
    aft_pkg::job_t back_job;
    logic          front_push;
    logic          fifo_full;
    logic          fifo_valid;
    logic          back_pop;
    logic [CW-1:0] fifo_level;

    // accept and classify
    aft_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .full      (fifo_full),
        .push      (front_push),
        .job       (front_job)
    );

    // decoupling queue
    aft_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (front_push),
        .wr_job (front_job),
        .full   (fifo_full),
        .pop    (back_pop),
        .valid  (fifo_valid),
        .rd_job (back_job),
        .level  (fifo_level)
    );

    // symbol serializer
    aft_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (fifo_valid),
        .job_in    (back_job),
        .pop       (back_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // checks
    `ASSERT_IMPLY(a_full_blocks_input, clk, rst_n, fifo_level == CW'(FIFO_DEPTH), !s_tready)
    `ASSERT_NEXT(a_accept_fills_queue, clk, rst_n, s_tvalid && s_tready, fifo_level != '0)
    `ASSERT_IMPLY(a_end_is_flag, clk, rst_n, m_tvalid && m_tlast, m_tuser && (m_tdata == aft_pkg::FLAG_BYTE))

endmodule

// ===== hw/rtl/aft_front.sv =====
`timescale 1ns / 1ps

module aft_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,
    input  logic             s_tuser,
    input  logic             s_tlast,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [7:0]       cfg_data,
    input  logic             full,
    output logic             push,
    output aft_pkg::job_t    job
);

    logic [7:0]  unit0_addr_reg;
    logic [7:0]  unit1_addr_reg;
    logic [15:0] crc_addr0_reg;
    logic [15:0] crc_addr1_reg;
    logic        inside_reg;
    logic        inside_next;
    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic [7:0]  addr_sel;
    logic [15:0] crc_base;
    logic [15:0] crc_new;

    // address registers, with the crc after each address kept beside it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit0_addr_reg <= aft_pkg::UNIT0_ADDR_RST;
            unit1_addr_reg <= aft_pkg::UNIT1_ADDR_RST;
            crc_addr0_reg  <= aft_pkg::CRC_ADDR0_RST;
            crc_addr1_reg  <= aft_pkg::CRC_ADDR1_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                aft_pkg::CFG_UNIT0:
                begin
                    unit0_addr_reg <= cfg_data;
                    crc_addr0_reg  <= aft_pkg::crc_byte(aft_pkg::CRC_INIT, cfg_data);
                end
                aft_pkg::CFG_UNIT1:
                begin
                    unit1_addr_reg <= cfg_data;
                    crc_addr1_reg  <= aft_pkg::crc_byte(aft_pkg::CRC_INIT, cfg_data);
                end
                default:
                begin
                    unit0_addr_reg <= unit0_addr_reg;
                end
            endcase
        end
    end

    // accept while the queue has room
    assign s_tready = !full;
    assign push     = s_tvalid && !full;

    // classify the request and run the crc over its payload byte
    always_comb
    begin
        addr_sel = s_tuser ? unit1_addr_reg : unit0_addr_reg;
        crc_base = inside_reg ? crc_reg : (s_tuser ? crc_addr1_reg : crc_addr0_reg);
        crc_new  = aft_pkg::crc_byte(crc_base, s_tdata);

        job.has_addr = !inside_reg;
        job.addr     = addr_sel;
        job.data     = s_tdata;
        job.last     = s_tlast;
        job.crc_fin  = ~crc_new;

        inside_next = inside_reg;
        crc_next    = crc_reg;
        if (push)
        begin
            inside_next = !s_tlast;
            crc_next    = s_tlast ? aft_pkg::CRC_INIT : crc_new;
        end
    end

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg <= 1'b0;
            crc_reg    <= aft_pkg::CRC_INIT;
        end
        else
        begin
            inside_reg <= inside_next;
            crc_reg    <= crc_next;
        end
    end

endmodule

// ===== hw/rtl/aft_fifo.sv =====
`timescale 1ns / 1ps

module aft_fifo
#(
    parameter int DEPTH = aft_pkg::FIFO_DEPTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  aft_pkg::job_t              wr_job,
    output logic                       full,
    input  logic                       pop,
    output logic                       valid,
    output aft_pkg::job_t              rd_job,
    output logic [$clog2(DEPTH+1)-1:0] level
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    aft_pkg::job_t mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_wr;
    logic          do_rd;

    assign full   = (count_reg == CW'(DEPTH));
    assign valid  = (count_reg != '0);
    assign level  = count_reg;
    assign rd_job = mem[rd_ptr_reg];
    assign do_wr  = push && !full;
    assign do_rd  = pop && valid;

    // pointer wrap and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/aft_back.sv =====
`timescale 1ns / 1ps

module aft_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    input  aft_pkg::job_t job_in,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [7:0]    m_tdata,
    output logic          m_tuser,
    output logic          m_tlast
);

    typedef enum logic [4:0] {
        STEP_ADDR = 5'b00001,
        STEP_DATA = 5'b00010,
        STEP_CRCL = 5'b00100,
        STEP_CRCH = 5'b01000,
        STEP_FLAG = 5'b10000
    } step_t;

    aft_pkg::job_t job_reg;
    logic          busy_reg;
    logic          busy_next;
    step_t         step_reg;
    step_t         step_next;
    step_t         step_adv;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [7:0]    out_byte_reg;
    logic          out_abit_reg;
    logic          out_end_reg;
    logic [7:0]    sym_byte;
    logic          sym_abit;
    logic          sym_end;
    logic          advance;
    logic          done;

    // symbol for the current step and the step after it
    always_comb
    begin
        sym_byte = job_reg.data;
        sym_abit = 1'b0;
        sym_end  = 1'b0;
        step_adv = step_reg;
        done     = 1'b0;
        unique case (step_reg)
            STEP_ADDR:
            begin
                sym_byte = job_reg.addr;
                sym_abit = 1'b1;
                step_adv = STEP_DATA;
            end
            STEP_DATA:
            begin
                step_adv = STEP_CRCL;
                done     = !job_reg.last;
            end
            STEP_CRCL:
            begin
                sym_byte = job_reg.crc_fin[7:0];
                step_adv = STEP_CRCH;
            end
            STEP_CRCH:
            begin
                sym_byte = job_reg.crc_fin[15:8];
                step_adv = STEP_FLAG;
            end
            STEP_FLAG:
            begin
                sym_byte = aft_pkg::FLAG_BYTE;
                sym_abit = 1'b1;
                sym_end  = 1'b1;
                done     = 1'b1;
            end
            default:
            begin
                done = 1'b1;
            end
        endcase
    end

    // one symbol per cycle while a job is loaded and the output stage can take it
    assign advance = busy_reg && (!out_valid_reg || m_tready);
    assign pop     = job_valid && (!busy_reg || (advance && done));

    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            step_next = job_in.has_addr ? STEP_ADDR : STEP_DATA;
        end
        else if (advance && done)
            busy_next = 1'b0;
        else if (advance)
            step_next = step_adv;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= STEP_DATA;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= job_in;
        if (advance)
        begin
            out_byte_reg <= sym_byte;
            out_abit_reg <= sym_abit;
            out_end_reg  <= sym_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_abit_reg;
    assign m_tlast  = out_end_reg;

endmodule

// ===== dv/tb_addressed_frame_transmitter_top.sv =====
`timescale 1ns / 1ps

module tb_addressed_frame_transmitter_top;

    // one line symbol as it leaves the block
    typedef struct packed {
        logic [7:0] sym;
        logic       addr_bit;
        logic       frame_end;
    } line_symbol_t;

    localparam int STALL_LIMIT = 5000;
    localparam int PRESSURE_HOLD = 300;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // data_byte
    logic       s_tuser = 1'b0;    // unit_select
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // symbol_byte
    logic       m_tuser;           // address_bit
    logic       m_tlast;
    logic       cfg_we = 1'b0;
    logic       cfg_index = 1'b0;
    logic [7:0] cfg_data = 8'h00;

    // framer state as predicted
    logic [7:0]  unit0_addr = aft_pkg::UNIT0_ADDR_RST;
    logic [7:0]  unit1_addr = aft_pkg::UNIT1_ADDR_RST;
    logic [15:0] frame_crc = aft_pkg::CRC_INIT;
    logic        in_frame = 1'b0;

    line_symbol_t pending_symbols[$];
    int           err_count = 0;
    int           stall_cycles = 0;
    int           hold_request = 0;
    bit           idle_on = 1'b1;

    addressed_frame_transmitter_top u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // reflected x-25 crc over one byte, lsb first
    function automatic logic [15:0] x25_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc;
        for (int i = 0; i < 8; i++)
        begin
            if (c[0] ^ b[i])
                c = (c >> 1) ^ 16'h8408;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // expected symbols for one accepted payload byte
    task automatic predict_symbols(input logic sel, input logic [7:0] data, input logic last);
        logic [7:0]  addr;
        logic [15:0] fin;
        if (!in_frame)
        begin
            addr = sel ? unit1_addr : unit0_addr;
            frame_crc = x25_next(aft_pkg::CRC_INIT, addr);
            in_frame = 1'b1;
            pending_symbols.push_back('{addr, 1'b1, 1'b0});
        end
        frame_crc = x25_next(frame_crc, data);
        pending_symbols.push_back('{data, 1'b0, 1'b0});
        if (last)
        begin
            fin = ~frame_crc;
            pending_symbols.push_back('{fin[7:0], 1'b0, 1'b0});
            pending_symbols.push_back('{fin[15:8], 1'b0, 1'b0});
            pending_symbols.push_back('{aft_pkg::FLAG_BYTE, 1'b1, 1'b1});
            frame_crc = aft_pkg::CRC_INIT;
            in_frame = 1'b0;
        end
    endtask

    // offer one payload byte and wait for its request to be taken
    task automatic send_byte(input logic sel, input logic [7:0] data, input logic last);
        while (idle_on && $urandom_range(0, 99) < 29)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = data;
        s_tuser  = sel;
        s_tlast  = last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_symbols(sel, data, last);
    endtask

    // stop offering and let every expected symbol come out
    task automatic drain_output();
        @(negedge clk);
        s_tvalid = 1'b0;
        wait (pending_symbols.size() == 0);
        repeat (8) @(posedge clk);
    endtask

    // address register write, only with the output drained
    task automatic write_address(input logic idx, input logic [7:0] val);
        drain_output();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge clk);
        if (idx == aft_pkg::CFG_UNIT0)
            unit0_addr = val;
        else
            unit1_addr = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // random frames, mostly short, some long, unit select random on every byte
    task automatic send_random_frames(input int n_items);
        int bytes_left;
        bytes_left = 0;
        for (int i = 0; i < n_items; i++)
        begin
            if (bytes_left == 0)
                bytes_left = ($urandom_range(0, 9) == 0) ? int'($urandom_range(9, 40))
                                                         : int'($urandom_range(1, 6));
            send_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), bytes_left == 1);
            bytes_left--;
        end
    endtask

    // reset addresses, single-byte frames and select changes mid-frame
    task automatic test_reset_addresses();
        send_byte(1'b0, 8'h00, 1'b1);
        send_byte(1'b1, 8'hFF, 1'b1);
        send_byte(1'b0, 8'h7E, 1'b0);
        send_byte(1'b1, 8'h55, 1'b0);
        send_byte(1'b0, 8'hAA, 1'b0);
        send_byte(1'b1, 8'h01, 1'b1);
        send_byte(1'b1, 8'h80, 1'b0);
        send_byte(1'b0, 8'hFE, 1'b1);
    endtask

    // extreme addresses and a write while a frame is open
    task automatic test_address_extremes();
        write_address(aft_pkg::CFG_UNIT0, 8'h00);
        write_address(aft_pkg::CFG_UNIT1, 8'hFF);
        send_byte(1'b0, 8'hFF, 1'b1);
        send_byte(1'b1, 8'h00, 1'b1);
        send_byte(1'b0, 8'h7F, 1'b0);
        write_address(aft_pkg::CFG_UNIT0, 8'h80);
        send_byte(1'b1, 8'h7E, 1'b0);
        send_byte(1'b0, 8'h00, 1'b1);
        send_byte(1'b0, 8'h3C, 1'b1);
        write_address(aft_pkg::CFG_UNIT1, 8'h7E);
        send_byte(1'b1, 8'hC3, 1'b0);
        send_byte(1'b1, 8'hFF, 1'b1);
    endtask

    // random traffic over several address settings
    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++)
        begin
            write_address(aft_pkg::CFG_UNIT0, 8'($urandom_range(0, 255)));
            write_address(aft_pkg::CFG_UNIT1, 8'($urandom_range(0, 255)));
            send_random_frames(70);
        end
    endtask

    // both sides at full rate
    task automatic test_full_rate();
        idle_on = 1'b0;
        send_random_frames(40);
        drain_output();
        idle_on = 1'b1;
    endtask

    // receiver holds off long enough for the input to stall
    task automatic test_backpressure();
        write_address(aft_pkg::CFG_UNIT0, 8'h24);
        write_address(aft_pkg::CFG_UNIT1, 8'h25);
        hold_request = PRESSURE_HOLD;
        send_random_frames(40);
    endtask

    // stimulus sequence
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_reset_addresses();
        test_address_extremes();
        test_random_traffic();
        test_full_rate();
        test_backpressure();
        @(negedge clk);
        s_tvalid = 1'b0;
        wait (pending_symbols.size() == 0);
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // output ready: random idling or a long hold-off
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                m_tready = 1'b0;
                hold_left--;
            end
            else if (!rst_n)
                m_tready = 1'b0;
            else if (idle_on)
                m_tready = ($urandom_range(0, 99) >= 29);
            else
                m_tready = 1'b1;
        end
    end

    // compare each emitted symbol with the oldest expected one
    initial
    begin
        line_symbol_t want;
        line_symbol_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got = '{m_tdata, m_tuser, m_tlast};
                if (pending_symbols.size() == 0)
                begin
                    $display("%0t: unexpected symbol byte %h addr_bit %b frame_end %b",
                             $time, got.sym, got.addr_bit, got.frame_end);
                    err_count++;
                end
                else
                begin
                    want = pending_symbols.pop_front();
                    if (got.sym !== want.sym || got.addr_bit !== want.addr_bit
                        || got.frame_end !== want.frame_end)
                    begin
                        $display("%0t: mismatch expected %h/%b/%b actual %h/%b/%b",
                                 $time, want.sym, want.addr_bit, want.frame_end,
                                 got.sym, got.addr_bit, got.frame_end);
                        err_count++;
                    end
                end
            end
        end
    end

    // watchdog on cycles with no request taken on either side
    initial
    begin
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles, %0d symbols outstanding",
                         $time, stall_cycles, pending_symbols.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

endmodule

// ===== addressed_frame_transmitter_top.f =====
+incdir+hw/rtl
hw/rtl/aft_pkg.sv
hw/rtl/aft_front.sv
hw/rtl/aft_fifo.sv
hw/rtl/aft_back.sv
hw/rtl/addressed_frame_transmitter_top.sv
dv/tb_addressed_frame_transmitter_top.sv
